// ----- sv/bblf_pkg.sv -----
// Shared types, widths and the reciprocal table of the box blur line filter.
`default_nettype none

package bblf_pkg;

    localparam int PIXEL_W        = 8;
    localparam int RADIUS_W       = 6;
    localparam int RADIUS_COUNT   = 1 << RADIUS_W;
    localparam int SUM_W          = 15;
    localparam int RING_DEPTH_DEF = 128;
    localparam int RING_DEPTH_MAX = 128;
    localparam int DIST_W         = $clog2(RING_DEPTH_MAX + 1);
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    // floor(w / m) == (w * ceil(2^RECIP_SHIFT / m)) >> RECIP_SHIFT for w < 2^SUM_W, m < 2^7
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

    typedef logic [RECIP_W-1:0] recip_table_t [RADIUS_COUNT];

    function automatic recip_table_t build_recip_table();
        recip_table_t tbl;
        int           m;
        int           num;
        int           rem;
        int           quo;
        for (int i = 0; i < RADIUS_COUNT; i++)
        begin
            m   = 2 * i + 1;
            num = RECIP_ONE + m - 1;
            rem = 0;
            quo = 0;
            // shift-subtract long division of num by m
            for (int b = RECIP_W - 1; b >= 0; b--)
            begin
                rem = (rem << 1) | ((num >> b) & 1);
                quo = quo << 1;
                if (rem >= m)
                begin
                    rem = rem - m;
                    quo = quo | 1;
                end
            end
            tbl[i] = RECIP_W'(quo);
        end
        return tbl;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

    // One step of work for the back end: a pixel arrival or one flush step.
    typedef struct packed {
        logic                arrive;     // write pixel into the ring
        logic                init;       // first pixel of a line: window = m * pixel
        logic                sub_first;  // dropped pixel lies before the line start
        logic                emit;       // window is centered on a real output
        logic                last;       // final output of the line
        logic [DIST_W-1:0]   back;       // dropped pixel, slots behind the write pointer
        logic [PIXEL_W-1:0]  pixel;      // pixel entering the window
        logic [RADIUS_W-1:0] rad;        // radius of this line
    } bblf_cmd_t;

endpackage

`default_nettype wire

// ----- sv/bblf_front.sv -----
// Front end: takes pixels, tracks line position and issues window-step commands.
`default_nettype none

module bblf_front #(
    parameter int RING_DEPTH = bblf_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bblf_pkg::PIXEL_W-1:0]  pixel_in,
    input  wire logic                          last_in,
    input  wire logic                          cfg_we,
    input  wire logic [bblf_pkg::RADIUS_W-1:0] cfg_wdata,
    input  wire logic                          q_full,
    output logic                               q_push,
    output bblf_pkg::bblf_cmd_t                q_push_data
);
    import bblf_pkg::*;

    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int XW = CW + 1;
    localparam logic [RADIUS_W-1:0] MAXR = RADIUS_W'((RING_DEPTH - 1) / 2);

    logic [RADIUS_W-1:0] radius_reg;
    logic                in_line_reg,  in_line_next;
    logic                flush_reg,    flush_next;
    logic [RADIUS_W-1:0] rad_reg,      rad_next;
    logic [RADIUS_W-1:0] k_reg,        k_next;
    logic [CW-1:0]       jcnt_reg,     jcnt_next;
    logic [PIXEL_W-1:0]  last_pix_reg, last_pix_next;

    logic [RADIUS_W-1:0] r_cfg, r_use;
    logic [CW-1:0]       j_use;
    logic [XW-1:0]       rx, two_r, jx;
    logic [XW-1:0]       rfx, two_rf, kx, jk;
    logic                accept;
    bblf_cmd_t           arrive_cmd, flush_cmd;

    assign r_cfg = (radius_reg > MAXR) ? MAXR : radius_reg;
    assign r_use = in_line_reg ? rad_reg : r_cfg;
    assign j_use = in_line_reg ? jcnt_reg : '0;

    assign rx    = XW'(r_use);
    assign two_r = rx + rx;
    assign jx    = XW'(j_use);

    assign rfx    = XW'(rad_reg);
    assign two_rf = rfx + rfx;
    assign kx     = XW'(k_reg);
    assign jk     = XW'(jcnt_reg) + kx;

    assign in_ready = !flush_reg && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        arrive_cmd.arrive    = 1'b1;
        arrive_cmd.init      = !in_line_reg;
        arrive_cmd.sub_first = jx < (two_r + XW'(1));
        arrive_cmd.back      = DIST_W'(two_r + XW'(1));
        arrive_cmd.emit      = jx >= rx;
        arrive_cmd.last      = last_in && (r_use == '0);
        arrive_cmd.pixel     = pixel_in;
        arrive_cmd.rad       = r_use;

        // flush step k: window center moves to j - r + k, past-end reads the last pixel
        flush_cmd.arrive     = 1'b0;
        flush_cmd.init       = 1'b0;
        flush_cmd.sub_first  = jk < (two_rf + XW'(1));
        flush_cmd.back       = DIST_W'(two_rf - kx + XW'(2));
        flush_cmd.emit       = jk >= rfx;
        flush_cmd.last       = k_reg == rad_reg;
        flush_cmd.pixel      = last_pix_reg;
        flush_cmd.rad        = rad_reg;
    end

    assign q_push      = accept || (flush_reg && !q_full);
    assign q_push_data = flush_reg ? flush_cmd : arrive_cmd;

    always_comb
    begin
        in_line_next  = in_line_reg;
        flush_next    = flush_reg;
        rad_next      = rad_reg;
        k_next        = k_reg;
        jcnt_next     = jcnt_reg;
        last_pix_next = last_pix_reg;
        if (accept)
        begin
            rad_next = r_use;
            if (last_in)
            begin
                in_line_next  = 1'b0;
                jcnt_next     = j_use;
                last_pix_next = pixel_in;
                if (r_use != '0)
                begin
                    flush_next = 1'b1;
                    k_next     = RADIUS_W'(1);
                end
            end
            else
            begin
                in_line_next = 1'b1;
                jcnt_next    = (j_use == CW'(RING_DEPTH)) ? j_use : j_use + CW'(1);
            end
        end
        else if (flush_reg && !q_full)
        begin
            k_next = k_reg + RADIUS_W'(1);
            if (k_reg == rad_reg)
            begin
                flush_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_RESET;
            in_line_reg <= 1'b0;
            flush_reg   <= 1'b0;
            rad_reg     <= '0;
            k_reg       <= '0;
            jcnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            in_line_reg <= in_line_next;
            flush_reg   <= flush_next;
            rad_reg     <= rad_next;
            k_reg       <= k_next;
            jcnt_reg    <= jcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_pix_reg <= last_pix_next;
    end

endmodule

`default_nettype wire

// ----- sv/bblf_cmd_queue.sv -----
// Small command queue between the front and back ends.
`default_nettype none

module bblf_cmd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bblf_pkg::bblf_cmd_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output bblf_pkg::bblf_cmd_t       head,
    output logic                      empty
);
    import bblf_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    bblf_cmd_t       slots [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg,  count_next;

    assign full  = count_reg == CNTW'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNTW'(1);
            2'b01:   count_next = count_reg - CNTW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bblf_back.sv -----
// Back end: pixel ring, running window sum, reciprocal divide and output register.
`default_nettype none

module bblf_back #(
    parameter int RING_DEPTH = bblf_pkg::RING_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bblf_pkg::bblf_cmd_t          q_head,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [bblf_pkg::PIXEL_W-1:0]      pixel_out,
    output logic                              last_out
);
    import bblf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [PIXEL_W-1:0]  ring [RING_DEPTH];
    logic [PIXEL_W-1:0]  rd_data_reg;
    logic [AW-1:0]       wp_reg;
    logic [AW:0]         addr_sum;
    logic [AW-1:0]       rd_addr;

    logic                en;
    logic                a_valid_reg;
    bblf_cmd_t           a_cmd_reg;

    logic [SUM_W-1:0]    window_sum_reg, window_sum_next;
    logic [PIXEL_W-1:0]  first_pixel_reg;
    logic [PIXEL_W-1:0]  sub_pix;
    logic [SUM_W:0]      step_sum;
    logic [SUM_W-1:0]    init_sum;

    logic                c_valid_reg;
    logic                c_last_reg;
    logic [RADIUS_W-1:0] c_rad_reg;

    logic                out_valid_reg;
    logic                out_last_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // whole back end advances together; hold while the output beat waits
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    assign addr_sum = {1'b0, wp_reg} + (AW+1)'(RING_DEPTH) - (AW+1)'(q_head.back);
    assign rd_addr  = (addr_sum >= (AW+1)'(RING_DEPTH)) ?
                      AW'(addr_sum - (AW+1)'(RING_DEPTH)) : AW'(addr_sum);

    // read before write: a slot rewritten this cycle still returns its old pixel
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_head.arrive)
            begin
                ring[wp_reg] <= q_head.pixel;
            end
            rd_data_reg <= ring[rd_addr];
        end
    end

    assign sub_pix  = a_cmd_reg.sub_first ? first_pixel_reg : rd_data_reg;
    assign init_sum = SUM_W'({a_cmd_reg.rad, 1'b1}) * SUM_W'(a_cmd_reg.pixel);
    assign step_sum = {1'b0, window_sum_reg} - (SUM_W+1)'(sub_pix)
                      + (SUM_W+1)'(a_cmd_reg.pixel);
    assign window_sum_next = a_cmd_reg.init ? init_sum : SUM_W'(step_sum);

    assign prod_next = PROD_W'(window_sum_reg) * PROD_W'(RECIP_TABLE[c_rad_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            a_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            window_sum_reg <= '0;
        end
        else if (en)
        begin
            if (q_pop && q_head.arrive)
            begin
                wp_reg <= (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            a_valid_reg <= q_pop;
            if (a_valid_reg)
            begin
                window_sum_reg <= window_sum_next;
            end
            c_valid_reg   <= a_valid_reg && a_cmd_reg.emit;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cmd_reg <= q_head;
            if (a_valid_reg && a_cmd_reg.init)
            begin
                first_pixel_reg <= a_cmd_reg.pixel;
            end
            c_last_reg   <= a_cmd_reg.last;
            c_rad_reg    <= a_cmd_reg.rad;
            prod_reg     <= prod_next;
            out_last_reg <= c_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = prod_reg[RECIP_SHIFT +: PIXEL_W];
    assign last_out  = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/box_blur_line_filter_core.sv -----
// A result beat passes the command queue, then the command, window sum and product registers.
// Throughput: one pixel per cycle while the command queue has room; the final pixel of a
// line with radius r adds r flush steps in the front end, during which in_ready is low.
// The back end moves one command per cycle while the output beat is not held: ring read, sum update, divide.
// Reset: rst_n asynchronous, active low; radius resets to 1, no line in progress.
`default_nettype none

module box_blur_line_filter_core #(
    parameter int RING_DEPTH = bblf_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bblf_pkg::PIXEL_W-1:0]  pixel_in,
    input  wire logic                          last_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bblf_pkg::PIXEL_W-1:0]       pixel_out,
    output logic                               last_out,
    input  wire logic                          cfg_we,
    input  wire logic [bblf_pkg::RADIUS_W-1:0] cfg_wdata
);
    import bblf_pkg::*;

    logic      q_push, q_full, q_pop, q_empty;
    bblf_cmd_t q_push_data, q_head;

    bblf_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .last_in     (last_in),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    bblf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    bblf_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .last_out  (last_out)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("command queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("command queue underflow");

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (q_push && !q_full))
        else $error("pixel beat accepted without a queue slot");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/blur_line_checker.sv -----
// Checker for the box blur line filter: watches both channels, predicts each blurred beat and compares.
module blur_line_checker
    import bblf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [PIXEL_W-1:0]  pixel_in,
    input  wire logic                last_in,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic [PIXEL_W-1:0]  pixel_out,
    input  wire logic                last_out,
    input  wire logic                cfg_we,
    input  wire logic [RADIUS_W-1:0] cfg_wdata,
    output int                       owed_beats,
    output int                       mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } blurred_beat_t;

    localparam int MAX_LINE_RADIUS = (RING_DEPTH - 1) / 2;

    blurred_beat_t      blurred_due[$];
    logic [PIXEL_W-1:0] line_hist [RING_DEPTH];
    logic [PIXEL_W-1:0] line_start_pix;
    int                 hist_wr;
    int                 taken_cnt;
    int                 given_cnt;
    int                 owed_cnt;
    int                 line_rad;
    int                 radius_reg;
    int                 bad;

    // pixel taken 'back' steps before the newest one
    function automatic logic [PIXEL_W-1:0] hist_back(input int back);
        return line_hist[(hist_wr + RING_DEPTH - 1 - (back % RING_DEPTH)) % RING_DEPTH];
    endfunction

    // Queue the oldest owed output; the newest pixel sits owed_cnt-1 places ahead of it.
    task automatic blur_emit(input logic fin);
        int            lag;
        int            d;
        int            acc;
        blurred_beat_t beat;
        lag = owed_cnt - 1;
        acc = 0;
        for (d = -line_rad; d <= line_rad; d++)
        begin
            if (d > lag)
                acc += hist_back(0);
            else if (given_cnt + d < 0)
                acc += line_start_pix;
            else
                acc += hist_back(lag - d);
        end
        beat.pixel = PIXEL_W'(acc / (2 * line_rad + 1));
        beat.last  = fin;
        blurred_due.push_back(beat);
        owed_cnt--;
        if (given_cnt < RING_DEPTH)
            given_cnt++;
    endtask

    task automatic blur_take_pixel(input logic [PIXEL_W-1:0] pix, input logic fin);
        // latch the radius at the first pixel of a line
        if (taken_cnt == 0)
        begin
            line_rad       = (radius_reg > MAX_LINE_RADIUS) ? MAX_LINE_RADIUS : radius_reg;
            line_start_pix = pix;
            given_cnt      = 0;
            owed_cnt       = 0;
        end
        line_hist[hist_wr] = pix;
        hist_wr = (hist_wr + 1) % RING_DEPTH;
        if (taken_cnt < RING_DEPTH)
            taken_cnt++;
        owed_cnt++;
        if (fin)
        begin
            // flush everything still owed for the line
            while (owed_cnt > 0)
                blur_emit(owed_cnt == 1);
            taken_cnt = 0;
            given_cnt = 0;
        end
        else if (owed_cnt > line_rad)
        begin
            blur_emit(1'b0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blurred_due.delete();
            foreach (line_hist[i])
                line_hist[i] = '0;
            line_start_pix = '0;
            hist_wr        = 0;
            taken_cnt      = 0;
            given_cnt      = 0;
            owed_cnt       = 0;
            line_rad       = 0;
            radius_reg     = int'(RADIUS_RESET);
            bad            = 0;
            owed_beats     <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
                radius_reg = int'(cfg_wdata);
            if (in_valid && in_ready)
                blur_take_pixel(pixel_in, last_in);
            if (out_valid && out_ready)
            begin
                if (blurred_due.size() == 0)
                begin
                    bad++;
                    $display("%0t: beat with nothing due, expected none, actual pixel %0d last %0b",
                             $time, pixel_out, last_out);
                end
                else
                begin
                    blurred_beat_t want;
                    want = blurred_due.pop_front();
                    if (want.pixel !== pixel_out || want.last !== last_out)
                    begin
                        bad++;
                        $display("%0t: beat mismatch, expected pixel %0d last %0b, actual pixel %0d last %0b",
                                 $time, want.pixel, want.last, pixel_out, last_out);
                    end
                end
            end
            owed_beats     <= blurred_due.size();
            mismatch_count <= bad;
        end
    end

endmodule

// ----- tb/sv/box_blur_line_filter_core_test.sv -----
// Top of the box blur line filter testbench: clock, reset, stimulus and verdict.
module box_blur_line_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bblf_pkg::*;

    localparam int RING_DEPTH  = RING_DEPTH_DEF;
    localparam int ITEM_TARGET = 390;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [PIXEL_W-1:0]  pixel_in  = '0;
    logic                last_in   = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PIXEL_W-1:0]  pixel_out;
    logic                last_out;
    logic                cfg_we    = 1'b0;
    logic [RADIUS_W-1:0] cfg_wdata = '0;

    int owed_beats;
    int mismatch_count;

    int items_sent = 0;
    int burst_left = 0;
    int carry_len  = 0;
    int cur_radius = 1;
    bit tx_calm    = 1'b0;
    bit rx_calm    = 1'b0;
    int run_left   = 0;
    int hold_left  = 0;

    box_blur_line_filter_core #(
        .RING_DEPTH(RING_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel_in (pixel_in),
        .last_in  (last_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_out(pixel_out),
        .last_out (last_out),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    blur_line_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_in      (pixel_in),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_out     (pixel_out),
        .last_out      (last_out),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .owed_beats    (owed_beats),
        .mismatch_count(mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: runs of ready broken by stalls, or always ready in calm phases.
    always @(posedge clk)
    begin
        if (rx_calm)
        begin
            out_ready <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (run_left > 0)
        begin
            out_ready <= 1'b1;
            run_left--;
        end
        else
        begin
            run_left  = $urandom_range(0, 15);
            hold_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
    end

    task automatic feed_pixel(input logic [PIXEL_W-1:0] pix, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = tx_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        last_in  <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic feed_line(input int len, input int mode, input bit close);
        logic [PIXEL_W-1:0] pix;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                1:       pix = '1;
                2:       pix = $urandom_range(0, 1) ? '1 : '0;
                default: pix = PIXEL_W'($urandom);
            endcase
            feed_pixel(pix, close && (i == len - 1));
        end
    endtask

    // Drop valid, drain every owed beat, then let the pipeline go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_beats != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_radius(input int value);
        cfg_we     <= 1'b1;
        cfg_wdata  <= RADIUS_W'(value);
        cur_radius = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_radius();
        case ($urandom_range(0, 9))
            0, 1:    return 0;
            2:       return (1 << RADIUS_W) - 1;
            3, 4:    return 1;
            5:       return $urandom_range(32, (1 << RADIUS_W) - 2);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return $urandom_range(100, 200);
            2:       return $urandom_range(cur_radius + 1, cur_radius + 3);
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    initial
    begin
        int n_lines;
        int len;
        int split;
        int mode;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radius of one on a four-pixel line, then a single-pixel line
        feed_pixel(8'd0, 1'b0);
        feed_pixel(8'd255, 1'b0);
        feed_pixel(8'd255, 1'b0);
        feed_pixel(8'd0, 1'b1);
        feed_pixel(8'd255, 1'b1);
        settle();

        // radius zero passes pixels through
        set_radius(0);
        feed_pixel(8'd17, 1'b0);
        feed_pixel(8'd200, 1'b0);
        feed_pixel(8'd0, 1'b0);
        feed_pixel(8'd255, 1'b1);
        settle();

        // widest window on lines shorter than the radius
        set_radius((1 << RADIUS_W) - 1);
        feed_pixel(8'd255, 1'b0);
        feed_pixel(8'd255, 1'b0);
        feed_pixel(8'd0, 1'b1);
        feed_pixel(8'd128, 1'b1);
        settle();

        // radius write in the middle of a line holds until the next line
        set_radius(2);
        feed_pixel(8'd10, 1'b0);
        feed_pixel(8'd250, 1'b0);
        feed_pixel(8'd30, 1'b0);
        feed_pixel(8'd240, 1'b0);
        feed_pixel(8'd50, 1'b0);
        settle();
        set_radius(0);
        feed_pixel(8'd60, 1'b0);
        feed_pixel(8'd70, 1'b0);
        feed_pixel(8'd80, 1'b1);
        feed_pixel(8'd90, 1'b0);
        feed_pixel(8'd1, 1'b1);
        settle();

        while (items_sent < ITEM_TARGET)
        begin
            set_radius(pick_radius());
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            mode    = $urandom_range(0, 5);
            if (mode > 2)
                mode = 0;
            // finish a line left open by the previous phase
            if (carry_len > 0)
            begin
                feed_line(carry_len, mode, 1'b1);
                carry_len = 0;
            end
            n_lines = $urandom_range(1, 3);
            for (int k = 0; k < n_lines; k++)
            begin
                len = pick_length();
                if (k == n_lines - 1 && len > 1 && $urandom_range(0, 4) == 0)
                begin
                    split = $urandom_range(1, len - 1);
                    feed_line(split, mode, 1'b0);
                    carry_len = len - split;
                end
                else
                begin
                    feed_line(len, mode, 1'b1);
                end
            end
            settle();
        end
        if (carry_len > 0)
        begin
            feed_line(carry_len, 0, 1'b1);
            settle();
        end

        if (mismatch_count == 0 && owed_beats == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- box_blur_line_filter_core.f -----
sv/bblf_pkg.sv
sv/bblf_front.sv
sv/bblf_cmd_queue.sv
sv/bblf_back.sv
sv/box_blur_line_filter_core.sv
tb/sv/blur_line_checker.sv
tb/sv/box_blur_line_filter_core_test.sv
